// File: rtl/mdv_pkg.sv
// Shared types, constants and verdict logic for the message deframer/validator.
`timescale 1ns / 1ps
`default_nettype none
package mdv_pkg;

   localparam int FifoDepth = 4;
   localparam int FifoAw    = $clog2(FifoDepth);
   localparam int TdataW    = 72;

   localparam logic [2:0] RegBigEndian  = 3'd0;
   localparam logic [2:0] RegIntroType  = 3'd1;
   localparam logic [2:0] RegOutroType  = 3'd2;
   localparam logic [2:0] RegNodeType   = 3'd3;
   localparam logic [2:0] RegSubType    = 3'd4;
   localparam logic [2:0] RegPubType    = 3'd5;
   localparam logic [2:0] RegRelayType  = 3'd6;

   localparam logic [7:0] DirBit   = 8'h80;
   localparam logic [7:0] FailBit  = 8'h40;

   localparam logic [15:0] IntroFixed = 16'd6;
   localparam logic [15:0] RelayFixed = 16'd11;
   localparam logic [15:0] NodeMin    = 16'd8;
   localparam logic [15:0] SubMin     = 16'd5;
   localparam logic [15:0] PubMin     = 16'd9;

   // header phase: descriptor, id, two length bytes, then payload
   localparam logic [2:0] HdrDesc    = 3'd0;
   localparam logic [2:0] HdrId      = 3'd1;
   localparam logic [2:0] HdrLenA    = 3'd2;
   localparam logic [2:0] HdrLenB    = 3'd3;
   localparam logic [2:0] HdrPayload = 3'd4;

   localparam logic KindPayload = 1'b0;
   localparam logic KindVerdict = 1'b1;

   typedef logic [1:0] verdict_type;
   localparam verdict_type VerdictOk       = 2'd0;
   localparam verdict_type VerdictRejected = 2'd1;
   localparam verdict_type VerdictShort    = 2'd2;
   localparam verdict_type VerdictUnknown  = 2'd3;

   typedef struct packed {
      logic       big_endian_lengths;
      logic [5:0] intro_type_code;
      logic [5:0] outro_type_code;
      logic [5:0] node_state_type_code;
      logic [5:0] subscription_type_code;
      logic [5:0] publish_type_code;
      logic [5:0] relay_type_code;
   } csr_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] byte_offset;
      logic [5:0]  msg_type;
      logic [7:0]  msg_id;
      logic        is_response;
      logic        sender_failure;
      logic [15:0] payload_length;
      verdict_type verdict;
      logic [7:0]  response_desc;
      logic        last;
   } result_type;

   typedef struct packed {
      logic push_a;
      logic push_b;
   } push_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  resp;
   } judge_type;

   function automatic judge_type judge(input logic [5:0] msg_type,
                                       input logic [15:0] len,
                                       input logic [15:0] inner,
                                       input csr_type csr);
      judge_type   j;
      logic [7:0]  ok;
      logic [7:0]  bad;
      logic [16:0] intro_need;
      logic [16:0] relay_need;
      ok         = DirBit | {2'b00, msg_type};
      bad        = DirBit | FailBit | {2'b00, msg_type};
      intro_need = {1'b0, inner} + {1'b0, IntroFixed};
      relay_need = {1'b0, inner} + {1'b0, RelayFixed};
      j.verdict  = VerdictUnknown;
      j.resp     = 8'h00;
      if (msg_type == csr.intro_type_code) begin
         if (len < IntroFixed) begin
            j.verdict = VerdictShort;
         end else begin
            // no acceptor attached: even the ok reply carries the failure bit
            j.resp    = bad;
            j.verdict = (intro_need > {1'b0, len}) ? VerdictRejected : VerdictOk;
         end
      end else if (msg_type == csr.outro_type_code) begin
         j.verdict = VerdictOk;
         j.resp    = ok;
      end else if (msg_type == csr.node_state_type_code) begin
         if (len < NodeMin) begin
            j.verdict = VerdictRejected;
            j.resp    = bad;
         end else begin
            j.verdict = VerdictOk;
            j.resp    = ok;
         end
      end else if (msg_type == csr.subscription_type_code) begin
         if (len < SubMin) begin
            j.verdict = VerdictShort;
         end else begin
            j.verdict = VerdictOk;
            j.resp    = ok;
         end
      end else if (msg_type == csr.publish_type_code) begin
         if (len < PubMin) begin
            j.verdict = VerdictShort;
         end else begin
            j.verdict = VerdictOk;
            j.resp    = ok;
         end
      end else if (msg_type == csr.relay_type_code) begin
         if (len < RelayFixed) begin
            j.verdict = VerdictShort;
         end else if (relay_need > {1'b0, len}) begin
            j.verdict = VerdictRejected;
            j.resp    = bad;
         end else begin
            j.verdict = VerdictOk;
            j.resp    = ok;
         end
      end
      return j;
   endfunction

endpackage
`default_nettype wire

// File: rtl/mdv_core.sv
// Input register, header/payload tracking and verdict generation.
`timescale 1ns / 1ps
`default_nettype none
module mdv_core (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [7:0]             data_byte,
   input  wire                    data_valid,
   output logic                   data_ready,
   input  mdv_pkg::csr_type       csr,
   input  wire                    room_two,
   output mdv_pkg::push_type      push,
   output mdv_pkg::result_type    res_a,
   output mdv_pkg::result_type    res_b
);
   import mdv_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  desc_ff, desc_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pay_cnt_ff, pay_cnt_in;
   logic [15:0] inner_ff, inner_in;
   logic        adv;
   logic [5:0]  cur_type;
   logic [15:0] pay_next;
   logic [15:0] byte_hi, byte_lo;
   judge_type   jv;
   result_type  verdict_res;
   result_type  payload_res;
   logic        fin_hdr, fin_pay;

   assign adv        = in_valid_ff && room_two;
   assign data_ready = !in_valid_ff || adv;
   assign cur_type   = desc_ff[5:0];
   assign byte_hi    = csr.big_endian_lengths ? {in_byte_ff, 8'h00} : {8'h00, in_byte_ff};
   assign byte_lo    = csr.big_endian_lengths ? {8'h00, in_byte_ff} : {in_byte_ff, 8'h00};
   assign pay_next   = pay_cnt_ff + 16'd1;

   always_comb begin
      hdr_cnt_in = hdr_cnt_ff;
      desc_in    = desc_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      pay_cnt_in = pay_cnt_ff;
      inner_in   = inner_ff;
      fin_hdr    = 1'b0;
      fin_pay    = 1'b0;
      case (hdr_cnt_ff)
         HdrId: begin
            id_in      = in_byte_ff;
            hdr_cnt_in = HdrLenB - 3'd1;
         end
         HdrLenA: begin
            len_in     = byte_hi;
            hdr_cnt_in = HdrLenB;
         end
         HdrLenB: begin
            len_in     = len_ff | byte_lo;
            inner_in   = 16'h0000;
            pay_cnt_in = 16'h0000;
            if (len_in == 16'h0000) begin
               fin_hdr    = 1'b1;
               hdr_cnt_in = HdrDesc;
            end else begin
               hdr_cnt_in = HdrPayload;
            end
         end
         HdrPayload: begin
            // embedded sub-length: intro at payload 4-5, relay at 9-10
            if (cur_type == csr.intro_type_code) begin
               if (pay_cnt_ff == 16'd4)      inner_in = byte_hi;
               else if (pay_cnt_ff == 16'd5) inner_in = inner_ff | byte_lo;
            end else if (cur_type == csr.relay_type_code) begin
               if (pay_cnt_ff == 16'd9)       inner_in = byte_hi;
               else if (pay_cnt_ff == 16'd10) inner_in = inner_ff | byte_lo;
            end
            pay_cnt_in = pay_next;
            if (pay_next >= len_ff) begin
               fin_pay    = 1'b1;
               hdr_cnt_in = HdrDesc;
               pay_cnt_in = 16'h0000;
            end
         end
         default: begin
            desc_in    = in_byte_ff;
            hdr_cnt_in = HdrId;
         end
      endcase
   end

   assign jv = judge(cur_type, len_in, inner_in, csr);

   always_comb begin
      payload_res                = '0;
      payload_res.kind           = KindPayload;
      payload_res.payload_byte   = in_byte_ff;
      payload_res.byte_offset    = pay_cnt_ff;
      payload_res.msg_type       = cur_type;
      payload_res.msg_id         = id_ff;
      payload_res.is_response    = desc_ff[7];
      payload_res.sender_failure = desc_ff[6];
      payload_res.payload_length = len_ff;

      verdict_res                = '0;
      verdict_res.kind           = KindVerdict;
      verdict_res.msg_type       = cur_type;
      verdict_res.msg_id         = id_ff;
      verdict_res.is_response    = desc_ff[7];
      verdict_res.sender_failure = desc_ff[6];
      verdict_res.payload_length = len_in;
      verdict_res.verdict        = jv.verdict;
      verdict_res.response_desc  = jv.resp;
      verdict_res.last           = 1'b1;
   end

   always_comb begin
      push.push_a = adv && (fin_hdr || (hdr_cnt_ff == HdrPayload));
      push.push_b = adv && fin_pay;
      res_a       = fin_hdr ? verdict_res : payload_res;
      res_b       = verdict_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hdr_cnt_ff  <= HdrDesc;
         desc_ff     <= 8'h00;
         id_ff       <= 8'h00;
         len_ff      <= 16'h0000;
         pay_cnt_ff  <= 16'h0000;
         inner_ff    <= 16'h0000;
      end else begin
         if (data_ready) begin
            in_valid_ff <= data_valid;
         end
         if (adv) begin
            hdr_cnt_ff <= hdr_cnt_in;
            desc_ff    <= desc_in;
            id_ff      <= id_in;
            len_ff     <= len_in;
            pay_cnt_ff <= pay_cnt_in;
            inner_ff   <= inner_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (data_ready && data_valid) begin
         in_byte_ff <= data_byte;
      end
   end

   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HdrPayload)
      else $error("header phase out of range");

   a_second_is_verdict: assert property (@(posedge clock) disable iff (reset)
      push.push_b |-> (push.push_a && res_b.kind == KindVerdict && res_a.kind == KindPayload))
      else $error("second result of a word must be a verdict after a payload byte");

   a_no_push_stalled: assert property (@(posedge clock) disable iff (reset)
      (push.push_a || push.push_b) |-> (room_two && in_valid_ff))
      else $error("push without room or without a held word");

endmodule
`default_nettype wire

// File: rtl/mdv_out_fifo.sv
// Small result queue taking up to two results per cycle and giving one while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module mdv_out_fifo (
   input  wire                    clock,
   input  wire                    reset,
   input  mdv_pkg::push_type      push,
   input  mdv_pkg::result_type    res_a,
   input  mdv_pkg::result_type    res_b,
   output logic                   room_two,
   output logic                   out_valid,
   input  wire                    out_ready,
   output mdv_pkg::result_type    out_res
);
   import mdv_pkg::*;

   result_type        mem_ff [FifoDepth];
   logic [FifoAw-1:0] wr_ff, wr_in;
   logic [FifoAw-1:0] rd_ff, rd_in;
   logic [FifoAw:0]   cnt_ff, cnt_in;
   logic              pop;
   logic [FifoAw-1:0] wr_next;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign out_res   = mem_ff[rd_ff];
   assign room_two  = (cnt_ff <= (FifoAw+1)'(FifoDepth - 2));
   assign wr_next   = wr_ff + FifoAw'(1);

   always_comb begin
      wr_in  = wr_ff + FifoAw'(push.push_a) + FifoAw'(push.push_b);
      rd_in  = rd_ff + FifoAw'(pop);
      cnt_in = cnt_ff + (FifoAw+1)'(push.push_a) + (FifoAw+1)'(push.push_b)
               - (FifoAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem_ff[wr_ff] <= res_a;
      end
      if (push.push_b) begin
         mem_ff[wr_next] <= res_b;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FifoAw+1)'(FifoDepth))
      else $error("result queue overflow");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.push_a && !push.push_b) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("pop without push did not drain one entry");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ff - rd_ff) == cnt_ff[FifoAw-1:0])
      else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

// File: rtl/message_deframer_validator.sv
// Top level of the message deframer/validator: ports, control registers, queue.
//
// Takes a byte stream of messages on req_ (one byte per word in req_tdata).
// Each message is a 4-byte header (descriptor, id, 16-bit length) and its
// payload. Every payload byte leaves on rsp_ with rsp_tuser = 0; after the
// last payload byte (or right after the header when the length is zero) one
// verdict word with rsp_tuser = 1 and rsp_tlast = 1 closes the message.
// A byte accepted on req_ is registered in the input register, judged
// there and written into the result queue, whose head drives rsp_.
// Throughput: one byte per cycle while the output is not stalled; the input
// register feeds a four-entry result queue and advances only while the queue
// has two free entries, so each message's verdict word adds an output word.
// csr_ writes are always taken (csr_ready high); register index in
// csr_index, value in the low bits of csr_data. Write them while idle.
// Reset clears the header tracking and the queue and loads the default
// type codes with big-endian lengths. When the receiver holds rsp_tready
// low the queue fills and req_tready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module message_deframer_validator (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,    // [7:0] data_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [mdv_pkg::TdataW-1:0] rsp_tdata,
   // [7:0] payload_byte, [23:8] byte_offset, [29:24] msg_type, [37:30] msg_id,
   // [38] is_response, [39] sender_failure, [55:40] payload_length,
   // [57:56] verdict, [65:58] response_desc, [71:66] zero
   output logic         rsp_tuser,    // [0] kind
   output logic         rsp_tlast,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [5:0]   csr_data
);
   import mdv_pkg::*;

   csr_type    csr_ff;
   push_type   push;
   result_type res_a;
   result_type res_b;
   result_type head;
   logic       room_two;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.big_endian_lengths     <= 1'b1;
         csr_ff.intro_type_code        <= 6'd0;
         csr_ff.outro_type_code        <= 6'd1;
         csr_ff.node_state_type_code   <= 6'd2;
         csr_ff.subscription_type_code <= 6'd3;
         csr_ff.publish_type_code      <= 6'd4;
         csr_ff.relay_type_code        <= 6'd5;
      end else if (csr_valid) begin
         case (csr_index)
            RegBigEndian: csr_ff.big_endian_lengths     <= csr_data[0];
            RegIntroType: csr_ff.intro_type_code        <= csr_data;
            RegOutroType: csr_ff.outro_type_code        <= csr_data;
            RegNodeType:  csr_ff.node_state_type_code   <= csr_data;
            RegSubType:   csr_ff.subscription_type_code <= csr_data;
            RegPubType:   csr_ff.publish_type_code      <= csr_data;
            RegRelayType: csr_ff.relay_type_code        <= csr_data;
            default: ;
         endcase
      end
   end

   mdv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .data_byte  (req_tdata),
      .data_valid (req_tvalid),
      .data_ready (req_tready),
      .csr        (csr_ff),
      .room_two   (room_two),
      .push       (push),
      .res_a      (res_a),
      .res_b      (res_b)
   );

   mdv_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res_a     (res_a),
      .res_b     (res_b),
      .room_two  (room_two),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (head)
   );

   assign rsp_tdata = {6'b000000, head.response_desc, head.verdict, head.payload_length,
                       head.sender_failure, head.is_response, head.msg_id,
                       head.msg_type, head.byte_offset, head.payload_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
`default_nettype wire
